/* hdl/ecma_pkg.sv */
// Shared types and constants of the eight-channel moving average.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package ecma_pkg;

   localparam int WINDOW_DEFAULT   = 25;
   localparam int CHANNELS_DEFAULT = 8;
   localparam int MAX_CHANNELS     = 8;
   localparam int SAMPLE_W         = 16;
   localparam int AVERAGE_W        = 24;
   localparam int FRAC_W           = 8;

   typedef logic signed [SAMPLE_W-1:0]  sample_type;
   typedef logic signed [AVERAGE_W-1:0] average_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

/* hdl/ecma_req_if.sv */
// Input channel of the moving average: valid/ready plus eight samples.
// Depends on ecma_pkg for the sample type.
`default_nettype none

interface ecma_req_if;
   logic                 valid;
   logic                 ready;
   ecma_pkg::sample_type sample_0;
   ecma_pkg::sample_type sample_1;
   ecma_pkg::sample_type sample_2;
   ecma_pkg::sample_type sample_3;
   ecma_pkg::sample_type sample_4;
   ecma_pkg::sample_type sample_5;
   ecma_pkg::sample_type sample_6;
   ecma_pkg::sample_type sample_7;

   modport source (
      output valid, sample_0, sample_1, sample_2, sample_3,
             sample_4, sample_5, sample_6, sample_7,
      input  ready
   );

   modport sink (
      input  valid, sample_0, sample_1, sample_2, sample_3,
             sample_4, sample_5, sample_6, sample_7,
      output ready
   );
endinterface

`default_nettype wire

/* hdl/ecma_rsp_if.sv */
// Result channel of the moving average: valid/ready plus eight averages.
// Depends on ecma_pkg for the average type.
`default_nettype none

interface ecma_rsp_if;
   logic                  valid;
   logic                  ready;
   ecma_pkg::average_type average_0;
   ecma_pkg::average_type average_1;
   ecma_pkg::average_type average_2;
   ecma_pkg::average_type average_3;
   ecma_pkg::average_type average_4;
   ecma_pkg::average_type average_5;
   ecma_pkg::average_type average_6;
   ecma_pkg::average_type average_7;

   modport source (
      output valid, average_0, average_1, average_2, average_3,
             average_4, average_5, average_6, average_7,
      input  ready
   );

   modport sink (
      input  valid, average_0, average_1, average_2, average_3,
             average_4, average_5, average_6, average_7,
      output ready
   );
endinterface

`default_nettype wire

/* hdl/eight_channel_moving_average.sv */
// Eight-channel boxcar moving average over the last WINDOW items.
// One item at a time: a new item is taken only once the bit-serial divider,
// DIV_W = 16 + clog2(WINDOW) + 8 bits wide, has finished the last one and its
// result has gone to the output register.
// Reset (synchronous): sums, fill count and ring pointer clear at once; the
// history memory is not cleared, since a slot is read only after being written.
`default_nettype none

module eight_channel_moving_average #(
   parameter int WINDOW   = ecma_pkg::WINDOW_DEFAULT,
   parameter int CHANNELS = ecma_pkg::CHANNELS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ecma_req_if.sink    req_ch,
   ecma_rsp_if.source  rsp_ch
);

   localparam int SAMPLE_W = ecma_pkg::SAMPLE_W;
   localparam int AVG_W    = ecma_pkg::AVERAGE_W;
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   // wide enough for WINDOW full-scale samples of either sign
   localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
   localparam int MAG_W    = SUM_W;
   localparam int DIV_W    = MAG_W + ecma_pkg::FRAC_W;
   localparam int WORD_W   = CHANNELS * SAMPLE_W;

   // ------------------------------------------------------------------
   // Sequencer state and control registers
   // ------------------------------------------------------------------
   ecma_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]         fill_ff;     // items held, 0..WINDOW
   logic [PTR_W-1:0]         ptr_ff;      // slot to write next (oldest once full)
   logic                     rsp_valid_ff;
   logic                     req_ready;
   logic                     req_fire;
   logic                     div_start;
   logic                     rsp_load;
   logic                     window_full;
   ecma_pkg::div_status_type div_st;

   // ------------------------------------------------------------------
   // History ring: one word of all channels per slot
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] hist_mem [WINDOW];
   logic [WORD_W-1:0] rd_word_ff;
   logic [WORD_W-1:0] wr_word;

   // ------------------------------------------------------------------
   // Per-channel data
   // ------------------------------------------------------------------
   ecma_pkg::sample_type     req_smp [ecma_pkg::MAX_CHANNELS];
   ecma_pkg::sample_type     smp_ff  [CHANNELS];
   logic signed [SUM_W-1:0]  sums_ff [CHANNELS];
   logic signed [SUM_W-1:0]  sums_in [CHANNELS];
   logic [MAG_W-1:0]         mag     [CHANNELS];
   logic [DIV_W-1:0]         quo     [CHANNELS];
   logic                     neg_ff  [CHANNELS];
   ecma_pkg::average_type    avg_ff  [CHANNELS];
   ecma_pkg::average_type    avg_out [ecma_pkg::MAX_CHANNELS];

   assign req_smp[0] = req_ch.sample_0;
   assign req_smp[1] = req_ch.sample_1;
   assign req_smp[2] = req_ch.sample_2;
   assign req_smp[3] = req_ch.sample_3;
   assign req_smp[4] = req_ch.sample_4;
   assign req_smp[5] = req_ch.sample_5;
   assign req_smp[6] = req_ch.sample_6;
   assign req_smp[7] = req_ch.sample_7;

   // Take an item only with no item in flight; the result register still
   // parts the sides, so a waiting result does not hold off the next item.
   assign req_ready    = (state_ff == ecma_pkg::ST_IDLE);
   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;
   assign window_full  = (fill_ff == CNT_W'(WINDOW));

   // ------------------------------------------------------------------
   // Sequencer: accept -> update sums and ring -> load divider -> divide
   // -> hand result to the output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecma_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ecma_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = ecma_pkg::ST_UPDATE;
            end
         end
         ecma_pkg::ST_UPDATE: begin
            state_in = ecma_pkg::ST_LOAD;
         end
         ecma_pkg::ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ecma_pkg::ST_DIVIDE;
         end
         ecma_pkg::ST_DIVIDE: begin
            if (div_st.done) begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_load = 1'b1;
                  state_in = ecma_pkg::ST_IDLE;
               end else begin
                  state_in = ecma_pkg::ST_DONE;
               end
            end
         end
         ecma_pkg::ST_DONE: begin
            // hold the quotients until the output register frees up
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ecma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ecma_pkg::ST_IDLE;
         end
      endcase
   end

   // The ring pointer advances once per item, in the update cycle; the fill count does too until the window is full.
   // Until the window fills, the pointer equals the fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ptr_ff  <= '0;
      end else if (state_ff == ecma_pkg::ST_UPDATE) begin
         if (!window_full) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (ptr_ff == PTR_W'(WINDOW - 1)) begin
            ptr_ff <= '0;
         end else begin
            ptr_ff <= ptr_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // History memory: read the slot at accept, write it back in the next cycle.
   // The sequencer takes no new item before the write, so read and write of
   // one slot never overlap.
   // ------------------------------------------------------------------
   for (genvar c = 0; c < CHANNELS; c++) begin : g_word
      assign wr_word[c*SAMPLE_W +: SAMPLE_W] = smp_ff[c];
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_word_ff <= hist_mem[ptr_ff];
      end
      if (state_ff == ecma_pkg::ST_UPDATE) begin
         hist_mem[ptr_ff] <= wr_word;
      end
   end

   // ------------------------------------------------------------------
   // Channel lanes: running sum, magnitude for the divider, sign fix-up
   // ------------------------------------------------------------------
   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      ecma_pkg::sample_type    old_smp;
      logic [AVG_W-1:0]        quo_lo;

      // drop the oldest sample only once the window is full
      always_comb begin
         old_smp    = window_full ? rd_word_ff[c*SAMPLE_W +: SAMPLE_W] : '0;
         sums_in[c] = sums_ff[c] + SUM_W'(smp_ff[c]) - SUM_W'(old_smp);
         mag[c]     = sums_ff[c][SUM_W-1] ? MAG_W'(~sums_ff[c] + 1'b1)
                                          : MAG_W'(sums_ff[c]);
         quo_lo     = quo[c][AVG_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (req_fire) begin
            smp_ff[c] <= req_smp[c];
         end
         if (div_start) begin
            neg_ff[c] <= sums_ff[c][SUM_W-1];
         end
         if (rsp_load) begin
            // quotient of the magnitude, negated back: truncation toward zero
            avg_ff[c] <= neg_ff[c] ? ecma_pkg::average_type'(~quo_lo + 1'b1)
                                   : ecma_pkg::average_type'(quo_lo);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sums_ff[c] <= '0;
         end else if (state_ff == ecma_pkg::ST_UPDATE) begin
            sums_ff[c] <= sums_in[c];
         end
      end
   end

   for (genvar c = 0; c < ecma_pkg::MAX_CHANNELS; c++) begin : g_out
      if (c < CHANNELS) begin : g_used
         assign avg_out[c] = avg_ff[c];
      end else begin : g_unused
         assign avg_out[c] = '0;
      end
   end

   // ------------------------------------------------------------------
   // Divider: (|sum| << 8) / fill_count in every lane
   // ------------------------------------------------------------------
   ecma_divider #(
      .LANES (CHANNELS),
      .MAG_W (MAG_W),
      .CNT_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (fill_ff),
      .dividend (mag),
      .quotient (quo),
      .status   (div_st)
   );

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.average_0 = avg_out[0];
   assign rsp_ch.average_1 = avg_out[1];
   assign rsp_ch.average_2 = avg_out[2];
   assign rsp_ch.average_3 = avg_out[3];
   assign rsp_ch.average_4 = avg_out[4];
   assign rsp_ch.average_5 = avg_out[5];
   assign rsp_ch.average_6 = avg_out[6];
   assign rsp_ch.average_7 = avg_out[7];

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW))
      else $error("fill count beyond window");

   a_ptr_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      !window_full |-> (CNT_W'(ptr_ff) == fill_ff))
      else $error("ring pointer out of step with fill count before full");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == ecma_pkg::ST_DIVIDE))
      else $error("divider finished outside the divide state");

   a_rsp_from_divider: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ecma_pkg::ST_DIVIDE ||
                                $past(state_ff) == ecma_pkg::ST_DONE))
      else $error("result raised without a finished division");

endmodule

`default_nettype wire

/* hdl/ecma_divider.sv */
// Multi-lane restoring divider, one quotient bit per cycle in every lane.
// All lanes share one small divisor. Depends on ecma_pkg.
`default_nettype none

module ecma_divider #(
   parameter int LANES = ecma_pkg::CHANNELS_DEFAULT,
   parameter int MAG_W = 21,
   parameter int CNT_W = 5
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [CNT_W-1:0]                divisor,
   input  wire logic [MAG_W-1:0]                dividend [LANES],
   output logic [MAG_W+ecma_pkg::FRAC_W-1:0]    quotient [LANES],
   output ecma_pkg::div_status_type             status
);

   localparam int DIV_W  = MAG_W + ecma_pkg::FRAC_W;
   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [CNT_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  rem_ff [LANES];
   logic [DIV_W-1:0]  quo_ff [LANES];

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(DIV_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   // lanes: shift one dividend bit into the remainder, subtract if it fits
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [CNT_W:0] shifted;
      logic [CNT_W:0] diff;

      always_comb begin
         shifted = {rem_ff[l], quo_ff[l][DIV_W-1]};
         diff    = shifted - {1'b0, dvs_ff};
      end

      always_ff @(posedge clock) begin
         if (start) begin
            rem_ff[l] <= '0;
            quo_ff[l] <= DIV_W'(dividend[l]) << ecma_pkg::FRAC_W;
         end else if (busy_ff) begin
            if (!diff[CNT_W]) begin
               rem_ff[l] <= diff[CNT_W-1:0];
               quo_ff[l] <= {quo_ff[l][DIV_W-2:0], 1'b1};
            end else begin
               rem_ff[l] <= shifted[CNT_W-1:0];
               quo_ff[l] <= {quo_ff[l][DIV_W-2:0], 1'b0};
            end
         end
      end

      assign quotient[l] = quo_ff[l];
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

/* dv/eight_channel_moving_average_test.sv */
// Testbench of the eight-channel moving average: directed fill patterns, then random streams
// checked item by item against an in-bench window predictor.
// Depends on ecma_pkg, ecma_req_if, ecma_rsp_if and eight_channel_moving_average.
`timescale 1ns / 1ps

module eight_channel_moving_average_test;

   localparam int WINDOW       = ecma_pkg::WINDOW_DEFAULT;
   localparam int CHANNELS     = ecma_pkg::CHANNELS_DEFAULT;
   localparam int MAX_CHANNELS = ecma_pkg::MAX_CHANNELS;
   localparam int SAMPLE_W     = ecma_pkg::SAMPLE_W;
   localparam int AVERAGE_W    = ecma_pkg::AVERAGE_W;
   // settle time after the last test, longer than one result takes to come back
   localparam int SETTLE_CYCLES = 64;

   typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0]  sample_vector_type;
   typedef logic [MAX_CHANNELS-1:0][AVERAGE_W-1:0] average_vector_type;

   logic clock = 1'b0;
   logic reset;

   ecma_req_if req_ch ();
   ecma_rsp_if rsp_ch ();

   eight_channel_moving_average #(
      .WINDOW   (WINDOW),
      .CHANNELS (CHANNELS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Window predictor: its own ring, sums and fill count
   // ------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] window_ring [0:WINDOW-1][0:MAX_CHANNELS-1];
   int                         channel_sums [0:MAX_CHANNELS-1];
   int                         held_count;
   int                         oldest_slot;

   // averages still owed by the block, oldest first
   average_vector_type pending_averages [$];

   int mismatch_count;
   int send_idle_pct;
   int recv_idle_pct;

   // Fold one accepted item into the window and queue the averages it must produce.
   task automatic predict_window_averages(input sample_vector_type samples);
      int                 slot;
      int                 value;
      longint             quotient;
      average_vector_type averages;
      if (held_count >= WINDOW) begin
         // window full: the new item overwrites the oldest and the oldest drops out of the sum
         slot = oldest_slot;
         for (int c = 0; c < CHANNELS; c++) begin
            value = $signed(samples[c]);
            channel_sums[c] += value - int'(window_ring[slot][c]);
            window_ring[slot][c] = samples[c];
         end
         oldest_slot = (slot + 1) % WINDOW;
      end else begin
         slot = (oldest_slot + held_count) % WINDOW;
         for (int c = 0; c < CHANNELS; c++) begin
            value = $signed(samples[c]);
            channel_sums[c] += value;
            window_ring[slot][c] = samples[c];
         end
         held_count++;
      end
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (c < CHANNELS) begin
            // signed division truncates toward zero, as the block must
            quotient = (longint'(channel_sums[c]) * 256) / longint'(held_count);
            averages[c] = quotient[AVERAGE_W-1:0];
         end else begin
            averages[c] = '0;
         end
      end
      pending_averages.push_back(averages);
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Sender: one item, with random idle cycles before it
   // ------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after acceptance with valid
   // still high, so back-to-back items never drop valid in between.
   task automatic send_samples(input sample_vector_type samples);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.sample_0 = samples[0];
      req_ch.sample_1 = samples[1];
      req_ch.sample_2 = samples[2];
      req_ch.sample_3 = samples[3];
      req_ch.sample_4 = samples[4];
      req_ch.sample_5 = samples[5];
      req_ch.sample_6 = samples[6];
      req_ch.sample_7 = samples[7];
      // hold the item until the block takes it
      do @(posedge clock); while (!req_ch.ready);
      predict_window_averages(samples);
      @(negedge clock);
   endtask

   // Hold the input idle and wait until every owed average has come back.
   task automatic drain_results();
      req_ch.valid = 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Receiver: random back-pressure, changed at the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   // ------------------------------------------------------------------
   // Result checker: compare each accepted result with the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      average_vector_type owed;
      average_vector_type seen;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = {rsp_ch.average_7, rsp_ch.average_6, rsp_ch.average_5, rsp_ch.average_4,
                 rsp_ch.average_3, rsp_ch.average_2, rsp_ch.average_1, rsp_ch.average_0};
         if (pending_averages.size() == 0) begin
            report_mismatch("result arrived with no item outstanding");
         end else begin
            owed = pending_averages.pop_front();
            for (int c = 0; c < MAX_CHANNELS; c++) begin
               if (seen[c] !== owed[c])
                  report_mismatch($sformatf("average_%0d: got %0d, expected %0d",
                                            c, $signed(seen[c]), $signed(owed[c])));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic sample_vector_type same_on_all(input logic [SAMPLE_W-1:0] value);
      sample_vector_type v;
      for (int c = 0; c < MAX_CHANNELS; c++) v[c] = value;
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Fill the window from empty with extremes, sign mixes, tiny values for truncation
   // toward zero, and a walking one through every bit of every channel.
   task automatic test_directed_fill();
      sample_vector_type v;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_samples(same_on_all(16'h7fff));   // count 1: full-scale positive
      send_samples(same_on_all(16'h8000));   // full-scale negative
      for (int c = 0; c < MAX_CHANNELS; c++) v[c] = (c % 2) ? 16'h8000 : 16'h7fff;
      send_samples(v);
      for (int c = 0; c < MAX_CHANNELS; c++) v[c] = (c % 2) ? 16'h7fff : 16'h8000;
      send_samples(v);
      send_samples(same_on_all(16'h0000));
      send_samples(same_on_all(16'hffff));   // small negative sums truncate toward zero
      send_samples(same_on_all(16'hffff));
      send_samples(same_on_all(16'h0001));
      for (int k = 0; k < SAMPLE_W; k++) begin
         for (int c = 0; c < MAX_CHANNELS; c++) v[c] = 16'(1) << ((k + c) % SAMPLE_W);
         send_samples(v);
      end
      for (int c = 0; c < MAX_CHANNELS; c++) v[c] = (c % 2) ? 16'haaaa : 16'h5555;
      send_samples(v);
      drain_results();
   endtask

   // Random stream in stretches: full-range noise, runs of extremes that can be long enough to
   // saturate the window sum, and tiny values that exercise truncation.
   task automatic test_random_stream(input int item_total, input int send_pct,
                                     input int recv_pct);
      int                sent;
      int                run_length;
      int                flavor;
      logic [15:0]       run_value;
      sample_vector_type v;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < item_total) begin
         run_length = $urandom_range(40, 1);
         flavor     = $urandom_range(9);
         run_value  = $urandom_range(1) ? 16'h7fff : 16'h8000;
         for (int n = 0; n < run_length && sent < item_total; n++) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
               case (flavor)
                  0: begin
                     v[c] = run_value;                       // constant extreme run
                  end
                  1: begin
                     v[c] = $urandom_range(1) ? 16'h7fff : 16'h8000;
                  end
                  2: begin
                     v[c] = 16'($signed($urandom_range(8)) - 4);
                  end
                  default: begin
                     v[c] = 16'($urandom);
                  end
               endcase
            end
            send_samples(v);
            sent++;
         end
      end
      drain_results();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      mismatch_count  = 0;
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      held_count      = 0;
      oldest_slot     = 0;
      for (int c = 0; c < MAX_CHANNELS; c++) channel_sums[c] = 0;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.sample_0 = '0;
      req_ch.sample_1 = '0;
      req_ch.sample_2 = '0;
      req_ch.sample_3 = '0;
      req_ch.sample_4 = '0;
      req_ch.sample_5 = '0;
      req_ch.sample_6 = '0;
      req_ch.sample_7 = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_fill();
      test_random_stream(660, 8, 50);    // receiver stalls often
      test_random_stream(660, 50, 8);    // sender gaps often
      test_random_stream(660, 0, 0);     // full rate

      // let any stray result show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_averages.size() == 0) begin
         $display("eight_channel_moving_average_test passed");
      end else begin
         $display("eight_channel_moving_average_test failed");
      end
      $finish;
   end

   // Watchdog: roughly 2000 items plus stalls take well under this.
   initial begin
      #5_000_000;
      $display("eight_channel_moving_average_test failed");
      $finish;
   end

endmodule

/* sim.f */
hdl/ecma_pkg.sv
hdl/ecma_req_if.sv
hdl/ecma_rsp_if.sv
hdl/ecma_divider.sv
hdl/eight_channel_moving_average.sv
dv/eight_channel_moving_average_test.sv
